### design/gto_pkg.sv
// Shared types and constants of the graph traversal order block.
package gto_pkg;

    localparam int NODE_W = 6;
    localparam int REQ_W = 2;
    localparam int NODE_LIMIT = 1 << NODE_W;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 8;

    localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic ST_NODE = 1'b0;
    localparam logic ST_DROPPED = 1'b1;

    typedef struct packed {
        logic push;
        logic flush;
        logic [NODE_W-1:0] node;
        logic status;
    } gto_emit_t;

    typedef struct packed {
        logic push_ok;
        logic flush_ok;
    } gto_obuf_stat_t;

endpackage

### design/gto_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gto_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/gto_obuf.sv
// Result buffer: one pending result and the output register that drives the master side.
module gto_obuf (
    input  logic                       clk,
    input  logic                       rst_n,
    input  gto_pkg::gto_emit_t         emit,
    output gto_pkg::gto_obuf_stat_t    stat,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [gto_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                       m_tlast,
    output logic                       m_tuser
);

    logic                        pend_valid_reg;
    logic                        pend_valid_next;
    logic [gto_pkg::NODE_W-1:0]  pend_node_reg;
    logic [gto_pkg::NODE_W-1:0]  pend_node_next;
    logic                        pend_status_reg;
    logic                        pend_status_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [gto_pkg::NODE_W-1:0]  out_node_reg;
    logic [gto_pkg::NODE_W-1:0]  out_node_next;
    logic                        out_last_reg;
    logic                        out_last_next;
    logic                        out_status_reg;
    logic                        out_status_next;
    logic                        out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign stat.push_ok = !pend_valid_reg || out_free;
    assign stat.flush_ok = out_free;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_node_next = pend_node_reg;
        pend_status_next = pend_status_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_node_next = out_node_reg;
        out_last_next = out_last_reg;
        out_status_next = out_status_reg;
        if (emit.flush && out_free)
        begin
            out_valid_next = 1'b1;
            out_node_next = pend_node_reg;
            out_status_next = pend_status_reg;
            out_last_next = 1'b1;
            pend_valid_next = 1'b0;
        end
        else if (emit.push && stat.push_ok)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_node_next = pend_node_reg;
                out_status_next = pend_status_reg;
                out_last_next = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_node_next = emit.node;
            pend_status_next = emit.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_node_reg <= pend_node_next;
        pend_status_reg <= pend_status_next;
        out_node_reg <= out_node_next;
        out_last_reg <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = gto_pkg::OUT_DATA_W'(out_node_reg);
    assign m_tlast = out_last_reg;
    assign m_tuser = out_status_reg;

endmodule

### design/graph_traversal_order.sv
// Top level: graph store, visited map and the traversal sequencer.
//
// Channel   Dir  Beat contents
// s_*       in   tuser: req_type; tdata: from_node, to_node, start_node (low bits up)
// m_*       out  tdata: visited_node; tlast: last_of_run; tuser: status
// cfg_*     in   cfg_wdata: traversal_mode, written when cfg_we is high
//
// An add-edge beat passes through ADD_CHK, then FINISH when the edge is dropped. A
// breadth-first run steps B_POP, B_TAKE, B_CNT, B_NRD per node taken from the queue and
// B_NCHK, B_NRD per neighbor-list entry read; a depth-first run steps D_TOP, D_CNT,
// D_CMP per look at a nonempty stack top and D_CHK per entry read. A stalled master
// side holds the sequencer where it emits a node. After reset the visited map and the
// per-node count valid bits are clear at once, so no clearing pass is needed.
module graph_traversal_order #(
    parameter int NODE_COUNT = 64,
    parameter int MAX_DEGREE = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [gto_pkg::IN_DATA_W-1:0]      s_tdata,  // from_node, to_node, start_node
    input  logic [gto_pkg::REQ_W-1:0]          s_tuser,  // req_type
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gto_pkg::OUT_DATA_W-1:0]     m_tdata,  // visited_node
    output logic                               m_tlast,
    output logic                               m_tuser,  // status
    input  logic                               cfg_we,
    input  logic                               cfg_wdata
);

    localparam int NODES = (NODE_COUNT < gto_pkg::NODE_LIMIT) ? NODE_COUNT
                                                              : gto_pkg::NODE_LIMIT;
    localparam int NIDX_W = $clog2(NODES);
    localparam int PTR_W = $clog2(NODES + 1);
    localparam int CNT_W = $clog2(MAX_DEGREE + 1);
    localparam int SA_W = $clog2(NODES * MAX_DEGREE);

    typedef enum logic [3:0] {
        IDLE, ADD_CHK, B_POP, B_TAKE, B_CNT, B_NRD, B_NCHK,
        D_TOP, D_CNT, D_CMP, D_CHK, FINISH
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic                 mode_reg;
    logic                 mode_next;
    logic [PTR_W-1:0]     head_reg;
    logic [PTR_W-1:0]     head_next;
    logic [PTR_W-1:0]     tail_reg;
    logic [PTR_W-1:0]     tail_next;
    logic [PTR_W-1:0]     depth_reg;
    logic [PTR_W-1:0]     depth_next;
    logic [NODES-1:0]     visited_reg;
    logic [NODES-1:0]     visited_next;
    logic [NODES-1:0]     cvalid_reg;
    logic [NODES-1:0]     cvalid_next;
    logic [NIDX_W-1:0]    cur_reg;
    logic [NIDX_W-1:0]    cur_next;
    logic [NIDX_W-1:0]    to_reg;
    logic [NIDX_W-1:0]    to_next;
    logic [CNT_W-1:0]     pos_reg;
    logic [CNT_W-1:0]     pos_next;
    logic [CNT_W-1:0]     len_reg;
    logic [CNT_W-1:0]     len_next;

    logic                 wl_we;
    logic [NIDX_W-1:0]    wl_waddr;
    logic [NIDX_W-1:0]    wl_wdata;
    logic [NIDX_W-1:0]    wl_raddr;
    logic [NIDX_W-1:0]    wl_rdata;
    logic                 nnp_we;
    logic [NIDX_W-1:0]    nnp_waddr;
    logic [CNT_W-1:0]     nnp_wdata;
    logic [CNT_W-1:0]     nnp_rdata;
    logic                 cnt_we;
    logic [CNT_W-1:0]     cnt_wdata;
    logic [NIDX_W-1:0]    cnt_raddr;
    logic [CNT_W-1:0]     cnt_rdata;
    logic                 st_we;
    logic [SA_W-1:0]      st_waddr;
    logic [SA_W-1:0]      st_raddr;
    logic [NIDX_W-1:0]    st_rdata;

    logic [gto_pkg::NODE_W-1:0] from_f;
    logic [gto_pkg::NODE_W-1:0] to_f;
    logic [gto_pkg::NODE_W-1:0] start_f;
    logic                 from_ok;
    logic                 to_ok;
    logic                 start_ok;
    logic                 accept;
    logic [NIDX_W-1:0]    top_idx;
    logic [CNT_W-1:0]     len_c;

    gto_pkg::gto_emit_t      emit;
    gto_pkg::gto_obuf_stat_t obuf_stat;

    assign from_f = s_tdata[5:0];
    assign to_f = s_tdata[11:6];
    assign start_f = s_tdata[17:12];
    assign from_ok = int'(from_f) < NODES;
    assign to_ok = int'(to_f) < NODES;
    assign start_ok = int'(start_f) < NODES;
    assign s_tready = (state_reg == IDLE);
    assign accept = s_tvalid && s_tready;
    assign top_idx = NIDX_W'(depth_reg - PTR_W'(1));
    assign len_c = cvalid_reg[cur_reg] ? cnt_rdata : '0;

    assign wl_raddr = (state_reg == B_POP || state_reg == B_TAKE) ? head_reg[NIDX_W-1:0]
                                                                  : top_idx;
    assign cnt_raddr = (state_reg == IDLE) ? from_f[NIDX_W-1:0] : wl_rdata;
    assign st_raddr = SA_W'(cur_reg) * SA_W'(MAX_DEGREE) + SA_W'(pos_reg);
    assign st_waddr = SA_W'(cur_reg) * SA_W'(MAX_DEGREE) + SA_W'(len_c);

    always_comb
    begin
        state_next = state_reg;
        mode_next = cfg_we ? cfg_wdata : mode_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        depth_next = depth_reg;
        visited_next = visited_reg;
        cvalid_next = cvalid_reg;
        cur_next = cur_reg;
        to_next = to_reg;
        pos_next = pos_reg;
        len_next = len_reg;
        wl_we = 1'b0;
        wl_waddr = tail_reg[NIDX_W-1:0];
        wl_wdata = st_rdata;
        nnp_we = 1'b0;
        nnp_waddr = top_idx;
        nnp_wdata = CNT_W'(pos_reg + CNT_W'(1));
        cnt_we = 1'b0;
        cnt_wdata = CNT_W'(len_c + CNT_W'(1));
        st_we = 1'b0;
        emit = '0;
        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        gto_pkg::REQ_ADD:
                        begin
                            if (from_ok && to_ok)
                            begin
                                cur_next = from_f[NIDX_W-1:0];
                                to_next = to_f[NIDX_W-1:0];
                                state_next = ADD_CHK;
                            end
                        end
                        gto_pkg::REQ_START:
                        begin
                            if (start_ok)
                            begin
                                visited_next[start_f[NIDX_W-1:0]] = 1'b1;
                                wl_we = 1'b1;
                                wl_waddr = '0;
                                wl_wdata = start_f[NIDX_W-1:0];
                                if (mode_reg)
                                begin
                                    emit.push = 1'b1;
                                    emit.node = start_f;
                                    emit.status = gto_pkg::ST_NODE;
                                    nnp_we = 1'b1;
                                    nnp_waddr = '0;
                                    nnp_wdata = '0;
                                    depth_next = PTR_W'(1);
                                    state_next = D_TOP;
                                end
                                else
                                begin
                                    head_next = '0;
                                    tail_next = PTR_W'(1);
                                    state_next = B_POP;
                                end
                            end
                        end
                        gto_pkg::REQ_CLEAR:
                        begin
                            visited_next = '0;
                            cvalid_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ADD_CHK:
            begin
                if (len_c < CNT_W'(MAX_DEGREE))
                begin
                    st_we = 1'b1;
                    cnt_we = 1'b1;
                    cvalid_next[cur_reg] = 1'b1;
                    state_next = IDLE;
                end
                else
                begin
                    emit.push = 1'b1;
                    emit.node = '0;
                    emit.status = gto_pkg::ST_DROPPED;
                    state_next = FINISH;
                end
            end
            B_POP:
            begin
                state_next = (head_reg == tail_reg) ? FINISH : B_TAKE;
            end
            B_TAKE:
            begin
                emit.push = 1'b1;
                emit.node = gto_pkg::NODE_W'(wl_rdata);
                emit.status = gto_pkg::ST_NODE;
                if (obuf_stat.push_ok)
                begin
                    cur_next = wl_rdata;
                    head_next = PTR_W'(head_reg + PTR_W'(1));
                    state_next = B_CNT;
                end
            end
            B_CNT:
            begin
                len_next = len_c;
                pos_next = '0;
                state_next = B_NRD;
            end
            B_NRD:
            begin
                state_next = (pos_reg == len_reg) ? B_POP : B_NCHK;
            end
            B_NCHK:
            begin
                if (!visited_reg[st_rdata] && tail_reg < PTR_W'(NODES))
                begin
                    visited_next[st_rdata] = 1'b1;
                    wl_we = 1'b1;
                    tail_next = PTR_W'(tail_reg + PTR_W'(1));
                end
                pos_next = CNT_W'(pos_reg + CNT_W'(1));
                state_next = B_NRD;
            end
            D_TOP:
            begin
                state_next = (depth_reg == '0) ? FINISH : D_CNT;
            end
            D_CNT:
            begin
                cur_next = wl_rdata;
                pos_next = nnp_rdata;
                state_next = D_CMP;
            end
            D_CMP:
            begin
                if (pos_reg < len_c)
                begin
                    nnp_we = 1'b1;
                    state_next = D_CHK;
                end
                else
                begin
                    depth_next = PTR_W'(depth_reg - PTR_W'(1));
                    state_next = D_TOP;
                end
            end
            D_CHK:
            begin
                if (!visited_reg[st_rdata] && depth_reg < PTR_W'(NODES))
                begin
                    emit.push = 1'b1;
                    emit.node = gto_pkg::NODE_W'(st_rdata);
                    emit.status = gto_pkg::ST_NODE;
                    if (obuf_stat.push_ok)
                    begin
                        visited_next[st_rdata] = 1'b1;
                        wl_we = 1'b1;
                        wl_waddr = depth_reg[NIDX_W-1:0];
                        nnp_we = 1'b1;
                        nnp_waddr = depth_reg[NIDX_W-1:0];
                        nnp_wdata = '0;
                        depth_next = PTR_W'(depth_reg + PTR_W'(1));
                        state_next = D_TOP;
                    end
                end
                else
                begin
                    state_next = D_TOP;
                end
            end
            FINISH:
            begin
                emit.flush = 1'b1;
                if (obuf_stat.flush_ok)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            mode_reg <= 1'b0;
            head_reg <= '0;
            tail_reg <= '0;
            depth_reg <= '0;
            visited_reg <= '0;
            cvalid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg <= mode_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            depth_reg <= depth_next;
            visited_reg <= visited_next;
            cvalid_reg <= cvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        to_reg <= to_next;
        pos_reg <= pos_next;
        len_reg <= len_next;
    end

    gto_ram #(
        .WIDTH (NIDX_W),
        .DEPTH (NODES)
    ) u_work_list (
        .clk   (clk),
        .we    (wl_we),
        .waddr (wl_waddr),
        .wdata (wl_wdata),
        .raddr (wl_raddr),
        .rdata (wl_rdata)
    );

    gto_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NODES)
    ) u_next_pos (
        .clk   (clk),
        .we    (nnp_we),
        .waddr (nnp_waddr),
        .wdata (nnp_wdata),
        .raddr (top_idx),
        .rdata (nnp_rdata)
    );

    gto_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NODES)
    ) u_count (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cur_reg),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    gto_ram #(
        .WIDTH (NIDX_W),
        .DEPTH (NODES * MAX_DEGREE)
    ) u_neighbors (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (to_reg),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    gto_obuf u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .emit     (emit),
        .stat     (obuf_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### sim/gto_order_checker.sv
// Checker that predicts the traversal output stream and compares every result beat.
module gto_order_checker
    import gto_pkg::*;
#(
    parameter int NODE_COUNT = 64,
    parameter int MAX_DEGREE = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [IN_DATA_W-1:0]      s_tdata,   // from_node, to_node, start_node
    input  logic [REQ_W-1:0]          s_tuser,   // req_type
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [OUT_DATA_W-1:0]     m_tdata,   // visited_node
    input  logic                      m_tlast,
    input  logic                      m_tuser,   // status
    input  logic                      cfg_we,
    input  logic                      cfg_wdata,
    output int                        fail_count,
    output int                        pending,
    output int                        results_seen,
    output int                        drops_seen
);

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              last;
        logic              status;
    } visit_t;

    logic [NODE_W-1:0] adj [NODE_COUNT][MAX_DEGREE];
    int                adj_len [NODE_COUNT];
    bit                seen [NODE_COUNT];
    bit                depth_first;
    logic [NODE_W-1:0] walk_order [$];
    visit_t            expected_visits [$];

    function automatic void trace_breadth(input logic [NODE_W-1:0] root);
        logic [NODE_W-1:0] fifo [$];
        logic [NODE_W-1:0] cur;
        logic [NODE_W-1:0] nb;
        fifo = {fifo, root};
        seen[root] = 1'b1;
        while (fifo.size() > 0)
        begin
            cur = fifo.pop_front();
            walk_order = {walk_order, cur};
            for (int i = 0; i < adj_len[cur]; i++)
            begin
                nb = adj[cur][i];
                if (!seen[nb])
                begin
                    seen[nb] = 1'b1;
                    fifo = {fifo, nb};
                end
            end
        end
    endfunction

    function automatic void trace_depth(input logic [NODE_W-1:0] root);
        logic [NODE_W-1:0] stack_node [NODE_COUNT];
        int                stack_pos [NODE_COUNT];
        int                depth;
        logic [NODE_W-1:0] cur;
        logic [NODE_W-1:0] nb;
        stack_node[0] = root;
        stack_pos[0] = 0;
        seen[root] = 1'b1;
        walk_order = {walk_order, root};
        depth = 1;
        while (depth > 0)
        begin
            cur = stack_node[depth-1];
            if (stack_pos[depth-1] < adj_len[cur])
            begin
                nb = adj[cur][stack_pos[depth-1]];
                stack_pos[depth-1]++;
                if (!seen[nb] && depth < NODE_COUNT)
                begin
                    seen[nb] = 1'b1;
                    walk_order = {walk_order, nb};
                    stack_node[depth] = nb;
                    stack_pos[depth] = 0;
                    depth++;
                end
            end
            else
            begin
                depth--;
            end
        end
    endfunction

    function automatic void predict_request(input logic [REQ_W-1:0] req,
                                            input logic [NODE_W-1:0] src,
                                            input logic [NODE_W-1:0] dst,
                                            input logic [NODE_W-1:0] root);
        visit_t v;
        case (req)
            REQ_ADD:
            begin
                if (adj_len[src] < MAX_DEGREE)
                begin
                    adj[src][adj_len[src]] = dst;
                    adj_len[src]++;
                end
                else
                begin
                    v = '{node: '0, last: 1'b1, status: ST_DROPPED};
                    expected_visits = {expected_visits, v};
                end
            end
            REQ_START:
            begin
                walk_order.delete();
                if (depth_first)
                    trace_depth(root);
                else
                    trace_breadth(root);
                foreach (walk_order[i])
                begin
                    v = '{node: walk_order[i], last: (i == walk_order.size() - 1),
                          status: ST_NODE};
                    expected_visits = {expected_visits, v};
                end
            end
            REQ_CLEAR:
            begin
                foreach (adj_len[i])
                begin
                    adj_len[i] = 0;
                    seen[i] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_result();
        visit_t want;
        results_seen++;
        if (m_tuser == ST_DROPPED)
            drops_seen++;
        if (expected_visits.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("Unexpected result beat at %0t: tdata %0h last %0b status %0b",
                         $time, m_tdata, m_tlast, m_tuser);
        end
        else
        begin
            want = expected_visits.pop_front();
            if (m_tdata !== OUT_DATA_W'(want.node) || m_tlast !== want.last
                || m_tuser !== want.status)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display(
                        "Mismatch at %0t (node last status): expected %0d %0b %0b, got %0d %0b %0b",
                        $time, want.node, want.last, want.status, m_tdata, m_tlast, m_tuser);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (adj_len[i])
            begin
                adj_len[i] = 0;
                seen[i] = 1'b0;
            end
            depth_first = 1'b0;
            expected_visits.delete();
            fail_count = 0;
            pending = 0;
            results_seen = 0;
            drops_seen = 0;
        end
        else
        begin
            if (cfg_we)
                depth_first = cfg_wdata;
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata[NODE_W-1:0], s_tdata[2*NODE_W-1:NODE_W],
                                s_tdata[3*NODE_W-1:2*NODE_W]);
            if (m_tvalid && m_tready)
                check_result();
            pending = expected_visits.size();
        end
    end

endmodule

### sim/tb_graph_traversal_order.sv
// Testbench top: drives edge, start, clear and unknown requests and gives the verdict.
module tb_graph_traversal_order;
    import gto_pkg::*;

    localparam int NODE_COUNT = 64;
    localparam int MAX_DEGREE = 64;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int DRAIN_CYCLES = 3 * (NODE_COUNT * MAX_DEGREE + NODE_COUNT) + 64;
    localparam int HOLD_CYCLES = 3000;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASE_ITEMS = 105;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic [REQ_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_we = 1'b0;
    logic                   cfg_wdata = 1'b0;

    int fail_count;
    int pending;
    int results_seen;
    int drops_seen;
    int cycle_count = 0;
    int items_sent = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    bit hold_trigger = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    graph_traversal_order #(
        .NODE_COUNT(NODE_COUNT),
        .MAX_DEGREE(MAX_DEGREE)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    gto_order_checker #(
        .NODE_COUNT(NODE_COUNT),
        .MAX_DEGREE(MAX_DEGREE)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .fail_count(fail_count),
        .pending(pending),
        .results_seen(results_seen),
        .drops_seen(drops_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // The long hold lets the block back up until it stalls its input.
    always @(negedge clk)
    begin
        if (hold_trigger && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready = 1'b0;
        end
        else
        begin
            m_tready = ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic logic [NODE_W-1:0] rand_node();
        return NODE_W'($urandom);
    endfunction

    task automatic send_beat(input logic [REQ_W-1:0] req, input logic [NODE_W-1:0] src,
                             input logic [NODE_W-1:0] dst, input logic [NODE_W-1:0] root);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = req;
        s_tdata = {6'b0, root, dst, src};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        s_tvalid = 1'b0;
        if (req != REQ_UNKNOWN)
            items_sent++;
    endtask

    task automatic drain_block();
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic depth_first);
        cfg_we = 1'b1;
        cfg_wdata = depth_first;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic fill_hub();
        logic [NODE_W-1:0] hub;
        hub = rand_node();
        send_beat(REQ_CLEAR, rand_node(), rand_node(), rand_node());
        repeat (MAX_DEGREE + $urandom_range(1, 3))
            send_beat(REQ_ADD, hub, rand_node(), rand_node());
        send_beat(REQ_START, rand_node(), rand_node(), hub);
    endtask

    task automatic random_session();
        int                span;
        logic [NODE_W-1:0] base;
        if ($urandom_range(7) == 0)
        begin
            send_beat(REQ_W'($urandom_range(3)), rand_node(), rand_node(), rand_node());
            return;
        end
        if ($urandom_range(3) != 0)
            send_beat(REQ_CLEAR, rand_node(), rand_node(), rand_node());
        case ($urandom_range(3))
            0: span = 4;
            1: span = 8;
            2: span = 16;
            default: span = NODE_COUNT;
        endcase
        base = rand_node();
        repeat ($urandom_range(2, 20))
            send_beat(REQ_ADD, NODE_W'(base + $urandom_range(span - 1)),
                      NODE_W'(base + $urandom_range(span - 1)), rand_node());
        repeat ($urandom_range(1, 3))
        begin
            if ($urandom_range(9) == 0)
                send_beat(REQ_UNKNOWN, rand_node(), rand_node(), rand_node());
            send_beat(REQ_START, rand_node(), rand_node(),
                      NODE_W'(base + $urandom_range(span - 1)));
        end
    endtask

    task automatic run_phase(input logic depth_first, input int idle_pct, input int stall_pct,
                             input bit with_hub, input bit with_hold);
        int first_item;
        drain_block();
        write_mode(depth_first);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        if (with_hold)
            hold_trigger = 1'b1;
        first_item = items_sent;
        if (with_hub)
            fill_hub();
        while (items_sent - first_item < PHASE_ITEMS)
            random_session();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Breadth-first at the reset mode: cycle through node 0, extremes 0 and 63.
        send_beat(REQ_ADD, 0, 1, 0);
        send_beat(REQ_ADD, 0, 2, 0);
        send_beat(REQ_ADD, 1, 3, 0);
        send_beat(REQ_ADD, 2, 3, 0);
        send_beat(REQ_ADD, 3, 0, 0);
        send_beat(REQ_ADD, 1, 63, 0);
        send_beat(REQ_ADD, 63, 62, 63);
        send_beat(REQ_ADD, 62, 2, 0);
        send_beat(REQ_START, 0, 0, 0);
        send_beat(REQ_START, 0, 0, 0);
        send_beat(REQ_START, 0, 0, 5);
        send_beat(REQ_UNKNOWN, 63, 63, 63);
        send_beat(REQ_ADD, 7, 7, 0);
        send_beat(REQ_START, 0, 0, 7);
        send_beat(REQ_START, 63, 63, 62);

        // Depth-first on a graph where the two orders differ.
        drain_block();
        write_mode(1'b1);
        send_beat(REQ_CLEAR, 63, 63, 63);
        send_beat(REQ_START, 0, 0, 0);
        send_beat(REQ_CLEAR, 0, 0, 0);
        send_beat(REQ_ADD, 0, 1, 0);
        send_beat(REQ_ADD, 0, 2, 0);
        send_beat(REQ_ADD, 1, 3, 0);
        send_beat(REQ_ADD, 3, 4, 0);
        send_beat(REQ_ADD, 2, 4, 0);
        send_beat(REQ_ADD, 4, 0, 0);
        send_beat(REQ_START, 0, 0, 0);

        run_phase(1'b0, 0, 0, 1'b1, 1'b0);
        run_phase(1'b1, 65, 0, 1'b0, 1'b0);
        run_phase(1'b0, 0, 65, 1'b1, 1'b1);
        run_phase(1'b1, 6, 6, 1'b0, 1'b0);
        drain_block();

        $display("Sent %0d requests in both traversal modes under four handshake patterns;",
                 items_sent);
        $display("checked %0d result beats, %0d of them dropped-edge reports.",
                 results_seen, drops_seen);
        if (pending != 0)
            $display("%0d expected result beats never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
design/gto_pkg.sv
design/gto_ram.sv
design/gto_obuf.sv
design/graph_traversal_order.sv
sim/gto_order_checker.sv
sim/tb_graph_traversal_order.sv
